// ===== hw/rtl/tcw_pkg.sv =====
// tcw_pkg: shared types, constants and codes for the text console char writer.
// Used by tcw_ctrl, tcw_datapath and text_console_char_writer_core.
// No dependencies.
package tcw_pkg;

    // Default geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Field widths
    localparam int OP_W     = 2;
    localparam int CHAR_W   = 8;
    localparam int COLOR_W  = 8;
    localparam int READ_W   = 11;
    localparam int CURSOR_W = 11;
    localparam int CELL_W   = CHAR_W + COLOR_W;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Control bytes and printable range
    localparam logic [CHAR_W-1:0] CH_BACKSPACE  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB        = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NEWLINE    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_FIRST_PRINT = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LAST_PRINT  = 8'h7F;

    // Blank cell: space on white-on-black
    localparam logic [CHAR_W-1:0]  BLANK_CHAR  = 8'h20;
    localparam logic [COLOR_W-1:0] BLANK_COLOR = 8'h0F;
    localparam logic [CELL_W-1:0]  BLANK_CELL  = {BLANK_COLOR, BLANK_CHAR};

    // Tab stops every 4 columns
    localparam logic [1:0] TAB_MASK = 2'b11;

    // Register file
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_TEXT_COLOR = 1'b0;
    localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'h0F;

    // Payload types
    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [CHAR_W-1:0] char_code;
        logic [READ_W-1:0] read_index;
    } tcw_request_t;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor_location;
        logic [CHAR_W-1:0]   cell_char;
        logic [COLOR_W-1:0]  cell_color;
    } tcw_result_t;

    // Sweep pointer operations
    typedef enum logic [2:0] {
        PTR_HOLD   = 3'd0,
        PTR_ZERO   = 3'd1,
        PTR_ROW1   = 3'd2,
        PTR_BOTTOM = 3'd3,
        PTR_INC    = 3'd4
    } tcw_ptr_op_t;

    // Controller to datapath commands
    typedef struct packed {
        logic        load;
        logic        exec;
        logic        home;
        logic        fill_step;
        logic        scroll_step;
        logic        read_issue;
        logic        respond;
        tcw_ptr_op_t ptr_op;
    } tcw_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            scroll_need;
        logic            ptr_last;
        logic            idx_ok;
    } tcw_status_t;

endpackage

// ===== hw/rtl/tcw_ctrl.sv =====
// tcw_ctrl: sequencing state machine for the text console char writer.
// Depends on tcw_pkg for command/status structs and operation codes.
module tcw_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  tcw_pkg::tcw_status_t status,
    output tcw_pkg::tcw_cmd_t    cmd,
    output logic                 busy
);

    typedef enum logic [7:0] {
        S_INIT    = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_EXEC    = 8'b0000_0100,
        S_SCROLL  = 8'b0000_1000,
        S_DRAIN   = 8'b0001_0000,
        S_BOTTOM  = 8'b0010_0000,
        S_FILL    = 8'b0100_0000,
        S_RESPOND = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.ptr_op = tcw_pkg::PTR_HOLD;
        case (state_reg)
            S_INIT:
            begin
                // power-up blanking pass
                cmd.fill_step = 1'b1;
                cmd.ptr_op    = tcw_pkg::PTR_INC;
                if (status.ptr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (status.op)
                    tcw_pkg::OP_PUT:
                    begin
                        cmd.exec   = 1'b1;
                        cmd.ptr_op = tcw_pkg::PTR_ROW1;
                        state_next = status.scroll_need ? S_SCROLL : S_RESPOND;
                    end
                    tcw_pkg::OP_CLEAR:
                    begin
                        cmd.home   = 1'b1;
                        cmd.ptr_op = tcw_pkg::PTR_ZERO;
                        state_next = S_FILL;
                    end
                    tcw_pkg::OP_READ:
                    begin
                        cmd.read_issue = status.idx_ok;
                        state_next     = S_RESPOND;
                    end
                    default:
                    begin
                        state_next = S_RESPOND;
                    end
                endcase
            end
            S_SCROLL:
            begin
                // copy row r+1 into row r, one cell per cycle
                cmd.scroll_step = 1'b1;
                if (status.ptr_last)
                begin
                    cmd.ptr_op = tcw_pkg::PTR_BOTTOM;
                    state_next = S_DRAIN;
                end
                else
                begin
                    cmd.ptr_op = tcw_pkg::PTR_INC;
                end
            end
            S_DRAIN:
            begin
                // last copy write lands here
                state_next = S_BOTTOM;
            end
            S_BOTTOM, S_FILL:
            begin
                cmd.fill_step = 1'b1;
                cmd.ptr_op    = tcw_pkg::PTR_INC;
                if (status.ptr_last)
                begin
                    state_next = S_RESPOND;
                end
            end
            S_RESPOND:
            begin
                cmd.respond = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/tcw_datapath.sv =====
// tcw_datapath: cell memory, cursor, sweep pointer and result register.
// Depends on tcw_pkg; driven by tcw_ctrl through tcw_cmd_t.
module tcw_datapath
#(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  tcw_pkg::tcw_cmd_t                 cmd,
    input  tcw_pkg::tcw_request_t             request,
    input  logic [tcw_pkg::COLOR_W-1:0]       text_color,
    output tcw_pkg::tcw_status_t              status,
    output logic                              done,
    output tcw_pkg::tcw_result_t              result
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int IXW   = ((AW > tcw_pkg::READ_W) ? AW : tcw_pkg::READ_W) + 1;

    localparam logic [AW-1:0]  PTR_LAST_C   = AW'(CELLS - 1);
    localparam logic [AW-1:0]  ROW1_C       = AW'(COLUMNS);
    localparam logic [AW-1:0]  BOTTOM_C     = AW'(CELLS - COLUMNS);
    localparam logic [CW:0]    COLUMNS_C    = (CW + 1)'(COLUMNS);
    localparam logic [RW:0]    ROWS_C       = (RW + 1)'(ROWS);
    localparam logic [RW-1:0]  LAST_ROW_C   = RW'(ROWS - 1);
    localparam logic [IXW-1:0] CELLS_C      = IXW'(CELLS);

    tcw_pkg::tcw_request_t req_reg;
    logic [CW-1:0]  col_reg;
    logic [RW-1:0]  row_reg;
    logic [AW-1:0]  ptr_reg;
    logic [AW-1:0]  ptr_next;
    logic           copy_pend_reg;
    logic [AW-1:0]  copy_addr_reg;
    logic [tcw_pkg::CELL_W-1:0] rdata_reg;
    logic           done_reg;
    tcw_pkg::tcw_result_t result_reg;

    logic [tcw_pkg::CELL_W-1:0] mem [CELLS];

    // Character decode
    logic [tcw_pkg::CHAR_W-1:0] ch;
    logic is_bs, is_tab, is_lf, is_cr, is_print;
    logic [CW-1:0] col_bs;
    logic [CW:0]   col_new;
    logic [CW:0]   col_final;
    logic          wrap;
    logic [RW:0]   row_new;
    logic [RW-1:0] row_final;
    logic          scroll_need;
    logic [CW-1:0] col_sel;
    logic [AW-1:0] lin;
    logic          idx_ok;

    // Memory port selection
    logic                        we;
    logic [AW-1:0]               waddr;
    logic [tcw_pkg::CELL_W-1:0]  wdata;
    logic                        re;
    logic [AW-1:0]               raddr;

    assign ch       = req_reg.char_code;
    assign is_bs    = (ch == tcw_pkg::CH_BACKSPACE);
    assign is_tab   = (ch == tcw_pkg::CH_TAB);
    assign is_lf    = (ch == tcw_pkg::CH_NEWLINE);
    assign is_cr    = (ch == tcw_pkg::CH_RETURN);
    assign is_print = (ch >= tcw_pkg::CH_FIRST_PRINT) && (ch <= tcw_pkg::CH_LAST_PRINT);
    assign col_bs   = (col_reg == '0) ? '0 : (col_reg - CW'(1));

    // Cursor column after the byte
    always_comb
    begin
        col_new = {1'b0, col_reg};
        if (is_bs)
        begin
            col_new = {1'b0, col_bs};
        end
        else if (is_tab)
        begin
            col_new = ({1'b0, col_reg} | (CW + 1)'(tcw_pkg::TAB_MASK)) + (CW + 1)'(1);
        end
        else if (is_lf || is_cr)
        begin
            col_new = '0;
        end
        else if (is_print)
        begin
            col_new = {1'b0, col_reg} + (CW + 1)'(1);
        end
    end

    // Wrap and scroll decision
    assign wrap        = (col_new >= COLUMNS_C);
    assign col_final   = wrap ? '0 : col_new;
    assign row_new     = {1'b0, row_reg} + (RW + 1)'(is_lf || wrap);
    assign scroll_need = (row_new >= ROWS_C);
    assign row_final   = scroll_need ? LAST_ROW_C : row_new[RW-1:0];

    // Linear address of the cursor (backspace target during exec)
    assign col_sel = (cmd.exec && is_bs) ? col_bs : col_reg;
    assign lin     = AW'(row_reg) * ROW1_C + AW'(col_sel);

    assign idx_ok = (IXW'(req_reg.read_index) < CELLS_C);

    // Status to controller
    assign status.op          = req_reg.operation;
    assign status.scroll_need = scroll_need;
    assign status.ptr_last    = (ptr_reg == PTR_LAST_C);
    assign status.idx_ok      = idx_ok;

    // Write port mux: pending copy, blank fill, or put
    always_comb
    begin
        we    = 1'b0;
        waddr = lin;
        wdata = tcw_pkg::BLANK_CELL;
        if (copy_pend_reg)
        begin
            we    = 1'b1;
            waddr = copy_addr_reg;
            wdata = rdata_reg;
        end
        else if (cmd.fill_step)
        begin
            we    = 1'b1;
            waddr = ptr_reg;
        end
        else if (cmd.exec && (is_bs || is_print))
        begin
            we    = 1'b1;
            wdata = is_bs ? tcw_pkg::BLANK_CELL : {text_color, ch};
        end
    end

    // Read port mux
    assign re    = cmd.scroll_step || cmd.read_issue;
    assign raddr = cmd.scroll_step ? ptr_reg : AW'(req_reg.read_index);

    // Cell memory
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // Sweep pointer
    always_comb
    begin
        case (cmd.ptr_op)
            tcw_pkg::PTR_HOLD:   ptr_next = ptr_reg;
            tcw_pkg::PTR_ZERO:   ptr_next = '0;
            tcw_pkg::PTR_ROW1:   ptr_next = ROW1_C;
            tcw_pkg::PTR_BOTTOM: ptr_next = BOTTOM_C;
            tcw_pkg::PTR_INC:    ptr_next = ptr_reg + AW'(1);
            default:             ptr_next = ptr_reg;
        endcase
    end

    // Control registers: pointer, copy stage, cursor, strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            copy_pend_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            ptr_reg       <= ptr_next;
            copy_pend_reg <= cmd.scroll_step;
            done_reg      <= cmd.respond;
            if (cmd.home)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (cmd.exec)
            begin
                col_reg <= col_final[CW-1:0];
                row_reg <= row_final;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
        copy_addr_reg <= ptr_reg - ROW1_C;
        if (cmd.respond)
        begin
            result_reg.cursor_location <= tcw_pkg::CURSOR_W'(lin);
            if ((req_reg.operation == tcw_pkg::OP_READ) && idx_ok)
            begin
                result_reg.cell_char  <= rdata_reg[tcw_pkg::CHAR_W-1:0];
                result_reg.cell_color <= rdata_reg[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
            end
            else
            begin
                result_reg.cell_char  <= '0;
                result_reg.cell_color <= '0;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== hw/rtl/text_console_char_writer_core.sv =====
// Text console char writer: put / clear / read on a ROWS x COLUMNS cell store.
// A put (no scroll) or a read raises done once the request has passed the EXEC and RESPOND
// states; a new request is taken only once busy is low again. A scroll or a clear extends
// the operation by a sweep over the cell memory.
// Reset: cursor homes, text_color = 0x0F, then busy stays high while the memory
// is blanked. Results cannot be stalled.
module text_console_char_writer_core
#(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  tcw_pkg::tcw_request_t             request,
    output logic                              done,
    output tcw_pkg::tcw_result_t              result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tcw_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [tcw_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [tcw_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    tcw_pkg::tcw_cmd_t    cmd;
    tcw_pkg::tcw_status_t status;
    logic [tcw_pkg::COLOR_W-1:0] text_color_reg;
    logic                        reg_sel;
    logic                        wr_xfer;

    // Register file: text_color at word 0
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_xfer = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= tcw_pkg::TEXT_COLOR_RESET;
        end
        else if (wr_xfer && (reg_sel == tcw_pkg::REG_TEXT_COLOR))
        begin
            text_color_reg <= pwdata[tcw_pkg::COLOR_W-1:0];
        end
    end

    assign prdata = (reg_sel == tcw_pkg::REG_TEXT_COLOR)
                  ? tcw_pkg::APB_DATA_W'(text_color_reg) : '0;

    tcw_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    tcw_datapath
    #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .request    (request),
        .text_color (text_color_reg),
        .status     (status),
        .done       (done),
        .result     (result)
    );

endmodule
